>>> rtl/hsvbc_pkg.sv
// Shared types, threshold tables and helper functions for the HSV box colour classifier.
// No dependencies; used by hsvbc_box_match and hsv_box_colour_window_classifier.
`default_nettype none

package hsvbc_pkg;

    localparam int NumClasses = 12;
    localparam int CountW     = 13;
    localparam int ClassW     = 4;
    localparam int ChanW      = 8;

    typedef logic [ChanW-1:0]  chan_t;
    typedef logic [CountW-1:0] count_t;
    typedef logic [ClassW-1:0] class_t;

    localparam count_t CountMax = {CountW{1'b1}};

    // inclusive bounds on hue, saturation, value
    typedef struct packed {
        chan_t h_lo;
        chan_t s_lo;
        chan_t v_lo;
        chan_t h_hi;
        chan_t s_hi;
        chan_t v_hi;
    } box_t;

    // vote candidate: count plus its class code
    typedef struct packed {
        count_t count;
        class_t idx;
    } cand_t;

    localparam box_t BlueTable [NumClasses] = '{
        '{8'd0,   8'd0,   8'd0,   8'd180, 8'd255, 8'd50 },
        '{8'd0,   8'd61,  8'd0,   8'd16,  8'd255, 8'd100},
        '{8'd131, 8'd28,  8'd45,  8'd180, 8'd255, 8'd204},
        '{8'd0,   8'd73,  8'd109, 8'd18,  8'd255, 8'd255},
        '{8'd29,  8'd0,   8'd0,   8'd39,  8'd255, 8'd255},
        '{8'd39,  8'd93,  8'd31,  8'd68,  8'd255, 8'd255},
        '{8'd104, 8'd141, 8'd0,   8'd113, 8'd255, 8'd155},
        '{8'd113, 8'd47,  8'd37,  8'd135, 8'd171, 8'd216},
        '{8'd96,  8'd0,   8'd43,  8'd138, 8'd55,  8'd255},
        '{8'd18,  8'd48,  8'd0,   8'd39,  8'd255, 8'd255},
        '{8'd84,  8'd0,   8'd105, 8'd110, 8'd75,  8'd255},
        '{8'd41,  8'd29,  8'd80,  8'd107, 8'd143, 8'd207}
    };

    // gold box is inverted, so it never matches
    localparam box_t GreenTable [NumClasses] = '{
        '{8'd30,  8'd0,   8'd0,   8'd180, 8'd255, 8'd66 },
        '{8'd8,   8'd102, 8'd0,   8'd39,  8'd255, 8'd125},
        '{8'd0,   8'd0,   8'd0,   8'd6,   8'd255, 8'd255},
        '{8'd10,  8'd180, 8'd0,   8'd18,  8'd255, 8'd255},
        '{8'd29,  8'd116, 8'd0,   8'd39,  8'd255, 8'd255},
        '{8'd47,  8'd87,  8'd0,   8'd76,  8'd255, 8'd255},
        '{8'd100, 8'd125, 8'd0,   8'd108, 8'd255, 8'd255},
        '{8'd84,  8'd80,  8'd46,  8'd137, 8'd132, 8'd164},
        '{8'd27,  8'd0,   8'd46,  8'd98,  8'd35,  8'd150},
        '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0  },
        '{8'd84,  8'd0,   8'd105, 8'd110, 8'd75,  8'd255},
        '{8'd41,  8'd29,  8'd80,  8'd107, 8'd143, 8'd207}
    };

    function automatic logic box_hit(box_t b, chan_t h, chan_t s, chan_t v);
        box_hit = (h >= b.h_lo) && (h <= b.h_hi) &&
                  (s >= b.s_lo) && (s <= b.s_hi) &&
                  (v >= b.v_lo) && (v <= b.v_hi);
    endfunction

    // a is the lower class code, so it keeps ties
    function automatic cand_t pick(cand_t a, cand_t b);
        pick = (b.count > a.count) ? b : a;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hsv_box_colour_window_classifier.sv
// HSV box colour classifier: per-pixel box tests, saturating class counters, window vote.
// Path: a window-end pixel's result reaches m_tdata through the input, count/snapshot, vote
// and output registers, in that order.
// Throughput: one pixel per cycle; backpressure from m_tready only stalls window-end pixels
// when the vote stages are full.
// Reset (aresetn, synchronous): counters, palette_mode and all valid flags cleared.
`default_nettype none

module hsv_box_colour_window_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] hue, [15:8] saturation, [23:16] brightness
    input  logic        s_tlast,   // window_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [3:0] colour_class, [7:4] zero
);
    import hsvbc_pkg::*;

    localparam logic [2:0] AddrMode = 3'd0;

    // configuration
    logic mode_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == AddrMode);
    assign prdata = (paddr == AddrMode) ? {31'b0, mode_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wr) begin
            mode_reg <= pwdata[0];
        end
    end

    // pipeline registers
    logic    p_valid_reg, p_last_reg, p_mode_reg;
    chan_t   p_hue_reg, p_sat_reg, p_bri_reg;
    count_t  count_reg [NumClasses];
    count_t  count_next [NumClasses];
    count_t  count_inc [NumClasses];
    logic    snap_valid_reg;
    count_t  snap_reg [NumClasses];
    logic    c_valid_reg;
    cand_t   cand_reg [3];
    cand_t   cand_next [3];
    cand_t   lvl1 [6];
    cand_t   final_pick;
    logic    m_valid_reg;
    class_t  m_class_reg;

    logic o_free, c_free, s_free, c_adv, s_adv, p_go;
    logic [NumClasses-1:0] hit;

    assign o_free   = !m_valid_reg || m_tready;
    assign c_adv    = c_valid_reg && o_free;
    assign c_free   = !c_valid_reg || o_free;
    assign s_adv    = snap_valid_reg && c_free;
    assign s_free   = !snap_valid_reg || c_free;
    assign p_go     = p_valid_reg && (!p_last_reg || s_free);
    assign s_tready = !p_valid_reg || p_go;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            p_hue_reg  <= s_tdata[7:0];
            p_sat_reg  <= s_tdata[15:8];
            p_bri_reg  <= s_tdata[23:16];
            p_last_reg <= s_tlast;
            p_mode_reg <= mode_reg;
        end
    end

    hsvbc_box_match u_match (
        .hue          (p_hue_reg),
        .saturation   (p_sat_reg),
        .brightness   (p_bri_reg),
        .palette_mode (p_mode_reg),
        .hit          (hit)
    );

    // saturating counters; cleared once the window-end pixel is counted
    always_comb begin
        for (int k = 0; k < NumClasses; k++) begin
            count_inc[k]  = (hit[k] && (count_reg[k] != CountMax)) ? count_reg[k] + count_t'(1)
                                                                  : count_reg[k];
            count_next[k] = count_reg[k];
            if (p_go) begin
                count_next[k] = p_last_reg ? '0 : count_inc[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NumClasses; k++) begin
                count_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NumClasses; k++) begin
                count_reg[k] <= count_next[k];
            end
        end
    end

    // snapshot of final counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (p_go && p_last_reg) begin
            snap_valid_reg <= 1'b1;
        end else if (s_adv) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_go && p_last_reg) begin
            for (int k = 0; k < NumClasses; k++) begin
                snap_reg[k] <= count_inc[k];
            end
        end
    end

    // vote: 12 -> 6 -> 3, registered, then 3 -> 1
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            lvl1[i] = pick(cand_t'{count: snap_reg[2*i],   idx: class_t'(2*i)},
                           cand_t'{count: snap_reg[2*i+1], idx: class_t'(2*i+1)});
        end
        for (int j = 0; j < 3; j++) begin
            cand_next[j] = pick(lvl1[2*j], lvl1[2*j+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_free) begin
            c_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_adv) begin
            for (int j = 0; j < 3; j++) begin
                cand_reg[j] <= cand_next[j];
            end
        end
    end

    assign final_pick = pick(pick(cand_reg[0], cand_reg[1]), cand_reg[2]);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_free) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_adv) begin
            m_class_reg <= final_pick.idx;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_class_reg};

    // checks
    a_snap_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        p_go && p_last_reg |=> snap_valid_reg)
        else $error("window end not captured in vote stage");

    a_counts_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        p_go && p_last_reg |=> (count_reg[0] == '0) && (count_reg[5] == '0) &&
                               (count_reg[11] == '0))
        else $error("class counters not cleared after window end");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_class_reg <= class_t'(NumClasses - 1)))
        else $error("colour class out of range");

    a_no_pixel_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && !p_last_reg |-> s_tready)
        else $error("mid-window pixel stalled the input");

endmodule

`default_nettype wire

>>> rtl/hsvbc_box_match.sv
// Tests one HSV pixel against all twelve class boxes of the selected palette.
// Depends on hsvbc_pkg (tables, box_hit).
`default_nettype none

module hsvbc_box_match (
    input  hsvbc_pkg::chan_t                  hue,
    input  hsvbc_pkg::chan_t                  saturation,
    input  hsvbc_pkg::chan_t                  brightness,
    input  logic                              palette_mode,
    output logic [hsvbc_pkg::NumClasses-1:0]  hit
);
    import hsvbc_pkg::*;

    always_comb begin
        for (int k = 0; k < NumClasses; k++) begin
            hit[k] = palette_mode ? box_hit(GreenTable[k], hue, saturation, brightness)
                                  : box_hit(BlueTable[k], hue, saturation, brightness);
        end
    end

endmodule

`default_nettype wire
